@@ sv/ccx_pkg.sv @@
// Package: shared types, constants and helpers of the ChaCha20 keystream XOR unit.
package ccx_pkg;

    // Cipher constants ("expand 32-byte k", little-endian words)
    localparam logic [3:0][31:0] SIGMA = {32'h6b206574, 32'h79622d32,
                                          32'h3320646e, 32'h61707865};
    localparam int NUM_DBL_ROUNDS = 10;
    localparam int ROT_A = 16;
    localparam int ROT_B = 12;
    localparam int ROT_C = 8;
    localparam int ROT_D = 7;

    // Round engine runs half a quarter-round per cycle: 4 phases per double round
    localparam int PHASE_W = 6;
    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(NUM_DBL_ROUNDS * 4 - 1);

    // Width of the byte position within a 64-byte keystream block
    localparam int POS_W = 6;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY1     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY3     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HI = 3'd5;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    // Items on the ports
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_message;
        logic       end_marker;
    } ccx_in_t;

    typedef struct packed {
        logic [7:0] result_byte;
        logic       end_flag;
    } ccx_out_t;

    // Queue entry: data byte with its keystream byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] ks_byte;
        logic       end_marker;
    } ccx_qent_t;

    // 16-word ChaCha state, word 0 in the low bits
    typedef logic [15:0][31:0] ccx_words_t;

    typedef struct packed {
        logic       start;
        ccx_words_t init;
    } ccx_core_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ccx_core_sts_t;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_ROUND,
        CORE_FINAL
    } ccx_core_state_t;

    function automatic logic [31:0] ccx_rotl(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

endpackage

@@ sv/ccx_core.sv @@
// Iterative ChaCha20 block engine: half a quarter-round on four lanes per cycle.
module ccx_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ccx_pkg::ccx_core_ctl_t ctl,
    output ccx_pkg::ccx_core_sts_t sts,
    output ccx_pkg::ccx_words_t   block
);
    import ccx_pkg::*;

    ccx_core_state_t state_reg, state_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    ccx_words_t x_reg, x_next, x_step;
    ccx_words_t init_reg, init_next;

    logic        half, diag;
    logic [1:0]  lane, sh1, sh2, sh3;
    logic [3:0]  qa, qb, qc, qd;
    logic [31:0] va, vb, vc, vd, a1, b1, c1, d1, dx, bx;

    assign half = phase_reg[0];
    assign diag = phase_reg[1];
    assign sh1  = diag ? 2'd1 : 2'd0;
    assign sh2  = diag ? 2'd2 : 2'd0;
    assign sh3  = diag ? 2'd3 : 2'd0;

    // One half quarter-round on each of the four independent lanes
    always_comb
    begin
        x_step = x_reg;
        lane = 2'd0;
        qa = 4'd0; qb = 4'd0; qc = 4'd0; qd = 4'd0;
        va = '0; vb = '0; vc = '0; vd = '0;
        a1 = '0; b1 = '0; c1 = '0; d1 = '0; dx = '0; bx = '0;
        for (int l = 0; l < 4; l++)
        begin
            lane = 2'(l);
            qa = {2'd0, lane};
            qb = {2'd1, 2'(lane + sh1)};
            qc = {2'd2, 2'(lane + sh2)};
            qd = {2'd3, 2'(lane + sh3)};
            va = x_reg[qa];
            vb = x_reg[qb];
            vc = x_reg[qc];
            vd = x_reg[qd];
            a1 = va + vb;
            dx = vd ^ a1;
            d1 = half ? ccx_rotl(dx, ROT_C) : ccx_rotl(dx, ROT_A);
            c1 = vc + d1;
            bx = vb ^ c1;
            b1 = half ? ccx_rotl(bx, ROT_D) : ccx_rotl(bx, ROT_B);
            x_step[qa] = a1;
            x_step[qb] = b1;
            x_step[qc] = c1;
            x_step[qd] = d1;
        end
    end

    // Feed-forward sum, valid in the final state
    always_comb
    begin
        for (int w = 0; w < 16; w++)
        begin
            block[w] = x_reg[w] + init_reg[w];
        end
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CORE_IDLE;
            phase_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    // Working state, no reset needed
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        init_reg <= init_next;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        x_next     = x_reg;
        init_next  = init_reg;
        sts.busy   = 1'b1;
        sts.done   = 1'b0;
        case (state_reg)
            CORE_IDLE:
            begin
                sts.busy = 1'b0;
                if (ctl.start)
                begin
                    x_next     = ctl.init;
                    init_next  = ctl.init;
                    phase_next = '0;
                    state_next = CORE_ROUND;
                end
            end
            CORE_ROUND:
            begin
                x_next     = x_step;
                phase_next = phase_reg + 1'b1;
                if (phase_reg == PHASE_LAST)
                begin
                    state_next = CORE_FINAL;
                end
            end
            CORE_FINAL:
            begin
                sts.done   = 1'b1;
                state_next = CORE_IDLE;
            end
            default:
            begin
                state_next = CORE_IDLE;
            end
        endcase
    end

endmodule

@@ sv/ccx_front.sv @@
// Front end: config registers, item accept, counter/position tracking, block prefetch.
module ccx_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [ccx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ccx_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  ccx_pkg::ccx_in_t           in_item,
    output logic                       push,
    output ccx_pkg::ccx_qent_t         push_entry,
    input  logic                       q_full,
    output ccx_pkg::ccx_core_ctl_t     core_ctl,
    input  ccx_pkg::ccx_core_sts_t     core_sts,
    input  ccx_pkg::ccx_words_t        core_block
);
    import ccx_pkg::*;

    logic [3:0][63:0] key_reg, key_next;
    logic [63:0]      nlo_reg, nlo_next;
    logic [31:0]      nhi_reg, nhi_next;

    logic [31:0]      ctr_reg, ctr_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    ccx_words_t       cur_blk_reg, cur_blk_next;
    ccx_words_t       pre_blk_reg, pre_blk_next;
    logic [31:0]      pre_ctr_reg, pre_ctr_next;
    logic             pre_ok_reg, pre_ok_next;
    logic [31:0]      job_ctr_reg, job_ctr_next;
    logic             job_dirty_reg, job_dirty_next;

    logic             cfg_we, need, hit, acc, store, start;
    logic [31:0]      want_ctr, need_ctr, ectr;
    logic [POS_W-1:0] epos;
    logic [511:0]     cur_flat;
    logic [7:0]       ks_byte;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid;

    // Block wanted next: counter 0 for a waiting start, else the next one in sequence
    always_comb
    begin
        if (in_valid && in_item.start_of_message)
        begin
            want_ctr = '0;
        end
        else if (pos_reg == '0)
        begin
            want_ctr = ctr_reg;
        end
        else
        begin
            want_ctr = ctr_reg + 32'd1;
        end
    end

    // Classify the waiting item: does it open a new block
    assign need     = in_item.start_of_message || (pos_reg == '0);
    assign need_ctr = in_item.start_of_message ? 32'd0 : ctr_reg;
    assign hit      = pre_ok_reg && (pre_ctr_reg == need_ctr);
    assign in_ready = !q_full && (!need || hit);
    assign acc      = in_valid && in_ready;
    assign epos     = in_item.start_of_message ? '0 : pos_reg;
    assign ectr     = in_item.start_of_message ? 32'd0 : ctr_reg;

    // Keystream byte selection
    assign cur_flat = cur_blk_reg;
    assign ks_byte  = need ? pre_blk_reg[0][7:0] : cur_flat[{pos_reg, 3'b000} +: 8];

    assign push                  = acc;
    assign push_entry.data_byte  = in_item.data_byte;
    assign push_entry.ks_byte    = ks_byte;
    assign push_entry.end_marker = in_item.end_marker;

    // Prefetch launch and result capture
    assign start = !core_sts.busy && !(pre_ok_reg && (pre_ctr_reg == want_ctr));
    assign store = core_sts.done && !job_dirty_reg && !cfg_we;

    always_comb
    begin
        core_ctl.start = start;
        for (int i = 0; i < 4; i++)
        begin
            core_ctl.init[i]         = SIGMA[i];
            core_ctl.init[4 + 2 * i] = key_reg[i][31:0];
            core_ctl.init[5 + 2 * i] = key_reg[i][63:32];
        end
        core_ctl.init[12] = want_ctr;
        core_ctl.init[13] = nlo_reg[31:0];
        core_ctl.init[14] = nlo_reg[63:32];
        core_ctl.init[15] = nhi_reg;
    end

    // Config register writes
    always_comb
    begin
        key_next = key_reg;
        nlo_next = nlo_reg;
        nhi_next = nhi_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_KEY0:     key_next[0] = cfg_data;
                CFG_KEY1:     key_next[1] = cfg_data;
                CFG_KEY2:     key_next[2] = cfg_data;
                CFG_KEY3:     key_next[3] = cfg_data;
                CFG_NONCE_LO: nlo_next    = cfg_data;
                CFG_NONCE_HI: nhi_next    = cfg_data[31:0];
                default:      ;
            endcase
        end
    end

    // Stream position and block buffers
    always_comb
    begin
        ctr_next       = ctr_reg;
        pos_next       = pos_reg;
        cur_blk_next   = cur_blk_reg;
        pre_blk_next   = pre_blk_reg;
        pre_ctr_next   = pre_ctr_reg;
        pre_ok_next    = pre_ok_reg;
        job_ctr_next   = job_ctr_reg;
        job_dirty_next = job_dirty_reg;

        if (acc)
        begin
            pos_next = epos + 1'b1;
            ctr_next = (&epos) ? ectr + 32'd1 : ectr;
            if (need)
            begin
                cur_blk_next = pre_blk_reg;
            end
        end

        if (store)
        begin
            pre_blk_next = core_block;
            pre_ctr_next = job_ctr_reg;
        end

        // A config write spoils any buffered or running prefetch
        if (cfg_we)
        begin
            pre_ok_next = 1'b0;
        end
        else if (store)
        begin
            pre_ok_next = 1'b1;
        end
        else if (acc && need)
        begin
            pre_ok_next = 1'b0;
        end

        if (start)
        begin
            job_ctr_next   = want_ctr;
            job_dirty_next = cfg_we;
        end
        else if (cfg_we)
        begin
            job_dirty_next = 1'b1;
        end
    end

    // Control and config state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg       <= '0;
            nlo_reg       <= '0;
            nhi_reg       <= '0;
            ctr_reg       <= '0;
            pos_reg       <= '0;
            pre_ok_reg    <= 1'b0;
            job_dirty_reg <= 1'b0;
        end
        else
        begin
            key_reg       <= key_next;
            nlo_reg       <= nlo_next;
            nhi_reg       <= nhi_next;
            ctr_reg       <= ctr_next;
            pos_reg       <= pos_next;
            pre_ok_reg    <= pre_ok_next;
            job_dirty_reg <= job_dirty_next;
        end
    end

    // Block data, no reset needed
    always_ff @(posedge clk)
    begin
        cur_blk_reg <= cur_blk_next;
        pre_blk_reg <= pre_blk_next;
        pre_ctr_reg <= pre_ctr_next;
        job_ctr_reg <= job_ctr_next;
    end

endmodule

@@ sv/ccx_queue.sv @@
// Short FIFO between the front end and the output stage.
module ccx_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ccx_pkg::ccx_qent_t push_entry,
    output logic               full,
    input  logic               pop,
    output logic               q_valid,
    output ccx_pkg::ccx_qent_t q_entry
);
    import ccx_pkg::*;

    ccx_qent_t           ent_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_reg, wr_next;
    logic [QUEUE_AW-1:0] rd_reg, rd_next;
    logic [QUEUE_AW:0]   cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign full    = (cnt_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_entry = ent_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    // Pointers and fill count
    always_comb
    begin
        wr_next  = do_push ? QUEUE_AW'(wr_reg + 1'b1) : wr_reg;
        rd_next  = do_pop ? QUEUE_AW'(rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_reg[wr_reg] <= push_entry;
        end
    end

endmodule

@@ sv/ccx_back.sv @@
// Back end: XOR with the keystream byte and the registered output stage.
module ccx_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  ccx_pkg::ccx_qent_t q_entry,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output ccx_pkg::ccx_out_t  out_item
);
    import ccx_pkg::*;

    logic     out_valid_reg, out_valid_next;
    ccx_out_t out_item_reg, out_item_next;

    // Load the output register when empty or being drained
    assign q_pop = q_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (q_pop)
        begin
            out_valid_next            = 1'b1;
            out_item_next.result_byte = q_entry.data_byte ^ q_entry.ks_byte;
            out_item_next.end_flag    = q_entry.end_marker;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

@@ sv/chacha20_keystream_xor_unit.sv @@
// Top level of the ChaCha20 keystream XOR unit.
//
//  channel | signals                           | direction | item
//  --------+-----------------------------------+-----------+------------------------------
//  cfg     | cfg_valid/cfg_ready, index, data  | in        | one register write
//  in      | in_valid/in_ready, in_item        | in        | data byte, start, end marker
//  out     | out_valid/out_ready, out_item     | out       | result byte, end flag
//
// One byte per cycle while input does not stall; an accepted byte goes into the queue
// and then into the registered output stage. A keystream block is computed in the round
// engine (half a quarter-round per cycle on four lanes) and the next block is prefetched,
// so input stalls only to open a block after a start of message, a config write or reset,
// waiting longer if an unwanted block must finish first, and while the queue is full.
// Reset (rst_n, async, active low) clears counter, position and all flags.
module chacha20_keystream_xor_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ccx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ccx_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  ccx_pkg::ccx_in_t               in_item,
    output logic                           out_valid,
    input  logic                           out_ready,
    output ccx_pkg::ccx_out_t              out_item
);
    import ccx_pkg::*;

    logic          push, q_full, q_pop, q_valid;
    ccx_qent_t     push_entry, q_entry;
    ccx_core_ctl_t core_ctl;
    ccx_core_sts_t core_sts;
    ccx_words_t    core_block;

    ccx_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (core_ctl),
        .sts   (core_sts),
        .block (core_block)
    );

    ccx_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full),
        .core_ctl   (core_ctl),
        .core_sts   (core_sts),
        .core_block (core_block)
    );

    ccx_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .q_valid    (q_valid),
        .q_entry    (q_entry)
    );

    ccx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

@@ sv/ccx_checker.sv @@
// Port-level checker for the ChaCha20 keystream XOR unit, bound to the top level.
module ccx_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  ccx_pkg::ccx_in_t               in_item,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  ccx_pkg::ccx_out_t              out_item
);
    import ccx_pkg::*;

    localparam logic [3:0] PEND_MAX = 4'(QUEUE_DEPTH + 1);

    logic [3:0] pend_reg, pend_next;
    logic       in_acc, out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // Items taken in but not yet delivered
    always_comb
    begin
        pend_next = pend_reg;
        if (in_acc && !out_acc)
        begin
            pend_next = pend_reg + 1'b1;
        end
        else if (out_acc && !in_acc)
        begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // Stalled input item holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_item))
        else $error("input item changed or dropped while stalled");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed or dropped while stalled");

    // No result without an item behind it
    a_out_backed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 4'd0)
        else $error("result shown with no item pending");

    // Queue plus output stage bound the items in flight
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= PEND_MAX)
        else $error("more items in flight than storage allows");

    // Register port never back-pressures
    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

endmodule

bind chacha20_keystream_xor_unit ccx_checker u_ccx_checker (.*);

@@ dv/tb_chacha20_keystream_xor_unit.sv @@
// Testbench of the ChaCha20 keystream XOR unit: byte streams checked against a cipher predictor.
`timescale 1ns / 100ps

module tb_chacha20_keystream_xor_unit;
    import ccx_pkg::*;

    // Register indexes past the end of the map; writes there are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    localparam int NUM_BYTES   = 1100;
    localparam int MAX_WAIT    = 6;
    localparam int CFG_SETTLE  = 3;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 20;

    typedef enum logic {ENT_BYTE, ENT_REG} ent_kind_t;

    // One pending stimulus entry: a data byte or a register write
    typedef struct packed {
        ent_kind_t                kind;
        ccx_in_t                  item;
        logic [CFG_IDX_W-1:0]     idx;
        logic [CFG_DATA_W-1:0]    data;
    } pend_ent_t;

    typedef logic [15:0][31:0] cc_state_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    ccx_in_t               in_item = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    ccx_out_t              out_item;

    // Stimulus and scoreboard
    pend_ent_t pend_q[$];
    ccx_out_t  due_bytes_q[$];
    int        n_stim_bytes = 0;
    int        n_results = 0;
    int        n_errors = 0;

    // Sender and receiver pacing
    int   snd_gap = 0;
    logic snd_calm = 1'b0;
    int   cfg_settle = CFG_SETTLE;
    int   rcv_stall = 0;
    logic rcv_calm = 1'b0;
    int   hold_left = 0;
    logic hold_done = 1'b0;

    // Predictor state: registers, counter, position and buffered keystream
    logic [63:0] mdl_key [4] = '{default: '0};
    logic [63:0] mdl_nonce_lo = '0;
    logic [31:0] mdl_nonce_hi = '0;
    logic [31:0] mdl_blk_ctr = '0;
    logic [5:0]  mdl_pos = '0;
    logic [7:0]  mdl_ks [64] = '{default: '0};

    chacha20_keystream_xor_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Quarter-round with fixed rotations 16, 12, 8, 7
    function automatic cc_state_t cc_quarter(cc_state_t x, int a, int b, int c, int d);
        logic [31:0] t;
        x[a] = x[a] + x[b]; t = x[d] ^ x[a]; x[d] = {t[15:0], t[31:16]};
        x[c] = x[c] + x[d]; t = x[b] ^ x[c]; x[b] = {t[19:0], t[31:20]};
        x[a] = x[a] + x[b]; t = x[d] ^ x[a]; x[d] = {t[23:0], t[31:24]};
        x[c] = x[c] + x[d]; t = x[b] ^ x[c]; x[b] = {t[24:0], t[31:25]};
        return x;
    endfunction

    // Compute the 64-byte keystream block for the current settings and counter
    function automatic void cc_refill_block();
        cc_state_t   init;
        cc_state_t   x;
        logic [31:0] w;
        // "expand 32-byte k"
        init[0] = 32'h61707865;
        init[1] = 32'h3320646e;
        init[2] = 32'h79622d32;
        init[3] = 32'h6b206574;
        for (int i = 0; i < 4; i++)
        begin
            init[4 + 2 * i] = mdl_key[i][31:0];
            init[5 + 2 * i] = mdl_key[i][63:32];
        end
        init[12] = mdl_blk_ctr;
        init[13] = mdl_nonce_lo[31:0];
        init[14] = mdl_nonce_lo[63:32];
        init[15] = mdl_nonce_hi;
        x = init;
        // 10 double rounds: columns then diagonals
        repeat (10)
        begin
            x = cc_quarter(x, 0, 4, 8, 12);
            x = cc_quarter(x, 1, 5, 9, 13);
            x = cc_quarter(x, 2, 6, 10, 14);
            x = cc_quarter(x, 3, 7, 11, 15);
            x = cc_quarter(x, 0, 5, 10, 15);
            x = cc_quarter(x, 1, 6, 11, 12);
            x = cc_quarter(x, 2, 7, 8, 13);
            x = cc_quarter(x, 3, 4, 9, 14);
        end
        // Feed-forward, little-endian serialization
        for (int i = 0; i < 16; i++)
        begin
            w = x[i] + init[i];
            for (int j = 0; j < 4; j++)
                mdl_ks[4 * i + j] = w[8 * j +: 8];
        end
    endfunction

    function automatic void cc_write_reg(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_KEY0:     mdl_key[0] = val;
            CFG_KEY1:     mdl_key[1] = val;
            CFG_KEY2:     mdl_key[2] = val;
            CFG_KEY3:     mdl_key[3] = val;
            CFG_NONCE_LO: mdl_nonce_lo = val;
            CFG_NONCE_HI: mdl_nonce_hi = val[31:0];
            default:      ;
        endcase
    endfunction

    // Expected result for one accepted byte; advances position and counter
    function automatic ccx_out_t cc_xor_byte(ccx_in_t it);
        ccx_out_t r;
        if (it.start_of_message)
        begin
            mdl_blk_ctr = '0;
            mdl_pos = '0;
        end
        if (mdl_pos == '0)
            cc_refill_block();
        r.result_byte = it.data_byte ^ mdl_ks[mdl_pos];
        r.end_flag = it.end_marker;
        mdl_pos = mdl_pos + 6'd1;
        if (mdl_pos == '0)
            mdl_blk_ctr = mdl_blk_ctr + 32'd1;
        return r;
    endfunction

    task automatic queue_byte(logic [7:0] d, logic som, logic eom);
        pend_ent_t e;
        e = '0;
        e.kind = ENT_BYTE;
        e.item.data_byte = d;
        e.item.start_of_message = som;
        e.item.end_marker = eom;
        pend_q = {pend_q, e};
        n_stim_bytes++;
    endtask

    task automatic queue_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        pend_ent_t e;
        e = '0;
        e.kind = ENT_REG;
        e.idx = idx;
        e.data = val;
        pend_q = {pend_q, e};
    endtask

    function automatic logic [63:0] pick_reg_value();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Mostly framed messages; now and then markers scattered at random
    task automatic queue_message(int len, logic lead_som);
        logic broken;
        broken = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < len; k++)
        begin
            if (broken)
                queue_byte(8'($urandom), $urandom_range(0, 15) == 0,
                           $urandom_range(0, 7) == 0);
            else
                queue_byte(8'($urandom), (k == 0) && lead_som, k == len - 1);
        end
    endtask

    // Stimulus, reset and end of run
    initial
    begin
        int   phase_end;
        int   len;
        logic lead;

        // Reset settings: all-zero key and nonce, field extremes, markers
        queue_byte(8'h00, 1'b1, 1'b0);
        queue_byte(8'hFF, 1'b0, 1'b0);
        queue_byte(8'hA5, 1'b0, 1'b0);
        queue_byte(8'h5A, 1'b0, 1'b1);
        queue_byte(8'h3C, 1'b1, 1'b1);
        queue_byte(8'hFF, 1'b1, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(8'h81, 1'b0, 1'b1);

        // All-ones settings, junk above nonce_high, writes to spare indexes
        queue_reg(CFG_KEY0, '1);
        queue_reg(CFG_KEY1, '1);
        queue_reg(CFG_KEY2, '1);
        queue_reg(CFG_KEY3, '1);
        queue_reg(CFG_NONCE_LO, '1);
        queue_reg(CFG_NONCE_HI, '1);
        queue_reg(CFG_SPARE_6, {$urandom, $urandom});
        queue_reg(CFG_SPARE_7, {$urandom, $urandom});

        // No start here: rest of the block still uses the old keystream
        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(8'hFF, 1'b0, 1'b0);
        queue_byte(8'h69, 1'b0, 1'b1);
        queue_byte(8'h00, 1'b1, 1'b0);
        queue_byte(8'hFF, 1'b0, 1'b0);
        queue_byte(8'h96, 1'b1, 1'b1);
        queue_byte(8'h00, 1'b0, 1'b1);

        // Random phases: new settings, then a run of messages
        while (n_stim_bytes < NUM_BYTES)
        begin
            phase_end = n_stim_bytes + $urandom_range(80, 200);
            if (phase_end > NUM_BYTES)
                phase_end = NUM_BYTES;
            for (int r = CFG_KEY0; r <= CFG_NONCE_HI; r++)
                if ($urandom_range(0, 1) != 0)
                    queue_reg(CFG_IDX_W'(r), pick_reg_value());
            if ($urandom_range(0, 3) == 0)
                queue_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_7 : CFG_SPARE_6,
                          {$urandom, $urandom});
            lead = ($urandom_range(0, 3) != 0);
            while (n_stim_bytes < phase_end)
            begin
                case ($urandom_range(0, 19))
                    0:       len = $urandom_range(129, 300);
                    1, 2, 3: len = $urandom_range(60, 128);
                    default: len = $urandom_range(1, 64);
                endcase
                if (len > NUM_BYTES - n_stim_bytes)
                    len = NUM_BYTES - n_stim_bytes;
                queue_message(len, lead);
                lead = 1'b1;
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pend_q.size() != 0 || in_valid || cfg_valid || due_bytes_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // Sender: data bytes and register writes from the pending queue
    always @(posedge clk)
    begin : sender
        logic                  nxt_in_valid;
        logic                  nxt_cfg_valid;
        ccx_in_t               nxt_item;
        logic [CFG_IDX_W-1:0]  nxt_idx;
        logic [CFG_DATA_W-1:0] nxt_data;
        pend_ent_t             ent;
        if (rst_n)
        begin
            nxt_in_valid = in_valid;
            nxt_cfg_valid = cfg_valid;
            nxt_item = in_item;
            nxt_idx = cfg_index;
            nxt_data = cfg_data;

            if (in_valid && in_ready)
            begin
                due_bytes_q = {due_bytes_q, cc_xor_byte(in_item)};
                nxt_in_valid = 1'b0;
                if ($urandom_range(0, 39) == 0)
                    snd_calm = !snd_calm;
                snd_gap = snd_calm ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (cfg_valid && cfg_ready)
            begin
                cc_write_reg(cfg_index, cfg_data);
                nxt_cfg_valid = 1'b0;
            end

            // Register writes wait until every result is back
            if (!nxt_in_valid && !nxt_cfg_valid && pend_q.size() != 0)
            begin
                if (snd_gap > 0)
                    snd_gap--;
                else if (pend_q[0].kind == ENT_BYTE)
                begin
                    ent = pend_q.pop_front();
                    nxt_in_valid = 1'b1;
                    nxt_item = ent.item;
                end
                else if (due_bytes_q.size() != 0)
                    cfg_settle = CFG_SETTLE;
                else if (cfg_settle > 0)
                    cfg_settle--;
                else
                begin
                    ent = pend_q.pop_front();
                    nxt_cfg_valid = 1'b1;
                    nxt_idx = ent.idx;
                    nxt_data = ent.data;
                    cfg_settle = CFG_SETTLE;
                end
            end

            in_valid <= nxt_in_valid;
            in_item <= nxt_item;
            cfg_valid <= nxt_cfg_valid;
            cfg_index <= nxt_idx;
            cfg_data <= nxt_data;
        end
    end

    // Receiver: check results in order, random stalls, one long hold-off
    always @(posedge clk)
    begin : receiver
        ccx_out_t want;
        logic     nxt_ready;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                n_results++;
                if (due_bytes_q.size() == 0)
                begin
                    $display("%0t: unexpected item, expected none, actual %h", $time, out_item);
                    n_errors++;
                end
                else
                begin
                    want = due_bytes_q.pop_front();
                    if (out_item.result_byte !== want.result_byte)
                    begin
                        $display("%0t: result_byte expected %h actual %h",
                                 $time, want.result_byte, out_item.result_byte);
                        n_errors++;
                    end
                    if (out_item.end_flag !== want.end_flag)
                    begin
                        $display("%0t: end_flag expected %b actual %b",
                                 $time, want.end_flag, out_item.end_flag);
                        n_errors++;
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    rcv_calm = !rcv_calm;
                rcv_stall = rcv_calm ? 0 : $urandom_range(0, MAX_WAIT);
            end

            if (hold_left > 0)
            begin
                hold_left--;
                nxt_ready = 1'b0;
            end
            else if (!hold_done && n_results >= HOLD_AT)
            begin
                // long back-pressure: the unit fills up and stalls its input
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                nxt_ready = 1'b0;
            end
            else if (rcv_stall > 0)
            begin
                rcv_stall--;
                nxt_ready = 1'b0;
            end
            else
                nxt_ready = 1'b1;
            out_ready <= nxt_ready;
        end
    end

endmodule

@@ files.f @@
sv/ccx_pkg.sv
sv/ccx_core.sv
sv/ccx_front.sv
sv/ccx_queue.sv
sv/ccx_back.sv
sv/chacha20_keystream_xor_unit.sv
sv/ccx_checker.sv
dv/tb_chacha20_keystream_xor_unit.sv
